>>> sv/trcpu_pkg.sv
package trcpu_pkg;

   // Item actions.
   localparam logic [2:0] ACT_EXECUTE  = 3'd0;
   localparam logic [2:0] ACT_LINE     = 3'd1;
   localparam logic [2:0] ACT_SET_ONE  = 3'd2;
   localparam logic [2:0] ACT_SET_TWO  = 3'd3;
   localparam logic [2:0] ACT_SET_PC   = 3'd4;

   // Opcodes, instruction bits 15..11.
   localparam logic [4:0] OP_NOP  = 5'd0;
   localparam logic [4:0] OP_MOV  = 5'd1;
   localparam logic [4:0] OP_HALT = 5'd2;
   localparam logic [4:0] OP_CMP  = 5'd3;
   localparam logic [4:0] OP_NOT  = 5'd4;
   localparam logic [4:0] OP_AND  = 5'd5;
   localparam logic [4:0] OP_OR   = 5'd6;
   localparam logic [4:0] OP_XOR  = 5'd7;
   localparam logic [4:0] OP_JMP  = 5'd8;

   // Operands, instruction bits 4..0.
   localparam logic [4:0] OPND_NONE      = 5'd0;
   localparam logic [4:0] MOV_ONE_TO_TWO = 5'd0;
   localparam logic [4:0] MOV_TWO_TO_ONE = 5'd1;
   localparam logic [4:0] MOV_ONE_TO_PC  = 5'd2;
   localparam logic [4:0] MOV_TWO_TO_PC  = 5'd3;
   localparam logic [4:0] MOV_LD_ONE_ONE = 5'd4;
   localparam logic [4:0] MOV_LD_TWO_TWO = 5'd5;
   localparam logic [4:0] MOV_LD_TWO_ONE = 5'd6;
   localparam logic [4:0] MOV_LD_ONE_TWO = 5'd7;
   localparam logic [4:0] MOV_STORE      = 5'd8;
   localparam logic [4:0] MOV_LD_ONE_PC  = 5'd9;
   localparam logic [4:0] MOV_LD_TWO_PC  = 5'd10;
   localparam logic [4:0] JMP_ONE        = 5'd0;
   localparam logic [4:0] JMP_TWO        = 5'd1;

   // What one request does: the register state after it when it needs no
   // memory read, plus the memory work it starts.
   typedef struct packed {
      logic [15:0] reg_one;
      logic [15:0] reg_two;
      logic [15:0] pc;
      logic        equal;
      logic        halt;
      logic        line_write;
      logic [15:0] line_addr;
      logic [7:0]  line_data;
      logic        mem_op;
      logic        store;
      logic        dest_one;
      logic [15:0] base;
   } plan_type;

endpackage

>>> sv/trcpu_ram.sv
module trcpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/trcpu_decode.sv
module trcpu_decode
   import trcpu_pkg::*;
(
   input  logic [2:0]  action,
   input  logic [15:0] instruction,
   input  logic [15:0] load_address,
   input  logic [15:0] load_value,
   input  logic [15:0] reg_one,
   input  logic [15:0] reg_two,
   input  logic [15:0] pc,
   input  logic        equal,
   input  logic        halted,
   output plan_type    plan
);

   logic [4:0]  opcode;
   logic [4:0]  operand;
   logic [15:0] before_pc;

   // A jump lands two below the register, but never below zero.
   function automatic logic [15:0] jump_target(input logic [15:0] r);
      return (r < 16'd2) ? 16'd0 : r - 16'd2;
   endfunction

   assign opcode    = instruction[15:11];
   assign operand   = instruction[4:0];
   assign before_pc = pc - 16'd2;

   always_comb begin
      plan            = '0;
      plan.reg_one    = reg_one;
      plan.reg_two    = reg_two;
      plan.pc         = pc;
      plan.equal      = equal;
      plan.halt       = halted;
      plan.line_addr  = load_address;
      plan.line_data  = load_value[7:0];
      plan.base       = reg_one;
      case (action)
         ACT_EXECUTE: begin
            if (!halted) begin
               case (opcode)
                  OP_MOV: begin
                     case (operand)
                        MOV_ONE_TO_TWO: plan.reg_two = reg_one;
                        MOV_TWO_TO_ONE: plan.reg_one = reg_two;
                        MOV_ONE_TO_PC:  plan.pc = reg_one;
                        MOV_TWO_TO_PC:  plan.pc = reg_two;
                        MOV_LD_ONE_ONE: begin
                           plan.mem_op   = 1'b1;
                           plan.dest_one = 1'b1;
                           plan.base     = reg_one;
                        end
                        MOV_LD_TWO_TWO: begin
                           plan.mem_op = 1'b1;
                           plan.base   = reg_two;
                        end
                        MOV_LD_TWO_ONE: begin
                           plan.mem_op = 1'b1;
                           plan.base   = reg_one;
                        end
                        MOV_LD_ONE_TWO: begin
                           plan.mem_op   = 1'b1;
                           plan.dest_one = 1'b1;
                           plan.base     = reg_two;
                        end
                        MOV_STORE: begin
                           plan.mem_op = 1'b1;
                           plan.store  = 1'b1;
                           plan.base   = reg_one;
                        end
                        MOV_LD_ONE_PC: begin
                           plan.mem_op   = 1'b1;
                           plan.dest_one = 1'b1;
                           plan.base     = before_pc;
                        end
                        MOV_LD_TWO_PC: begin
                           plan.mem_op = 1'b1;
                           plan.base   = before_pc;
                        end
                        default: ;
                     endcase
                  end
                  OP_HALT: plan.halt = 1'b1;
                  OP_CMP: begin
                     if (operand == OPND_NONE) plan.equal = (reg_one == reg_two);
                  end
                  OP_NOT: begin
                     if (operand == OPND_NONE) plan.reg_one = ~reg_one;
                  end
                  OP_AND: begin
                     if (operand == OPND_NONE) plan.reg_one = reg_one & reg_two;
                  end
                  OP_OR: begin
                     if (operand == OPND_NONE) plan.reg_one = reg_one | reg_two;
                  end
                  OP_XOR: begin
                     if (operand == OPND_NONE) plan.reg_one = reg_one ^ reg_two;
                  end
                  OP_JMP: begin
                     if (operand == JMP_ONE) begin
                        plan.pc = jump_target(reg_one);
                     end else if (operand == JMP_TWO) begin
                        plan.pc = jump_target(reg_two);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ACT_LINE:    plan.line_write = 1'b1;
         ACT_SET_ONE: plan.reg_one = load_value;
         ACT_SET_TWO: plan.reg_two = load_value;
         ACT_SET_PC:  plan.pc = load_value;
         default: ;
      endcase
   end

endmodule

>>> sv/two_register_toy_cpu_core.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   action, instruction, load_address, load_value
// rsp_      out        rsp_valid/rsp_stall   pc, reg one, reg two, equal, error, halted
//
// Register, set and line-write requests can follow back to back while responses are not stalled.
// A two-line load reads two lines, an indirect store does 4 pointer reads, then 0, 1
// or 2 writes; all line traffic goes through the single byte-wide RAM read and write ports.
// After reset the RAM is cleared one line a cycle, all 2^ADDRESS_BITS lines, with req_stall high.
// A request is taken while the previous response is being handed over; a stalled
// response holds the core.
module two_register_toy_cpu_core
   import trcpu_pkg::*;
#(
   parameter int ADDRESS_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_instruction,
   input  logic [15:0] req_load_address,
   input  logic [15:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pc_value,
   output logic [15:0] rsp_reg_one_value,
   output logic [15:0] rsp_reg_two_value,
   output logic        rsp_equal_flag,
   output logic        rsp_memory_error,
   output logic        rsp_halted
);

   localparam int LINES = 1 << ADDRESS_BITS;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_WRHI  = 3'd4;
   localparam logic [2:0] S_WRLO  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [ADDRESS_BITS-1:0] clr_ff, clr_in;
   logic [ADDRESS_BITS-1:0] base_ff, base_in;
   logic [ADDRESS_BITS-1:0] ptr_ff, ptr_in;
   logic [1:0]              issue_ff, issue_in;
   logic [1:0]              last_idx_ff, last_idx_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [23:0]             acc_ff, acc_in;
   logic                    store_ff, store_in;
   logic                    dest_one_ff, dest_one_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             reg_one_ff, reg_one_in;
   logic [15:0]             reg_two_ff, reg_two_in;
   logic [15:0]             pc_ff, pc_in;
   logic                    equal_ff, equal_in;
   logic                    error_ff, error_in;
   logic                    halt_ff, halt_in;

   logic                    accept;
   logic                    ram_we;
   logic [ADDRESS_BITS-1:0] ram_waddr;
   logic [7:0]              ram_wdata;
   logic [ADDRESS_BITS-1:0] ram_raddr;
   logic [7:0]              ram_rdata;
   logic [31:0]             full;
   plan_type                plan;

   trcpu_decode u_decode (
      .action       (req_action),
      .instruction  (req_instruction),
      .load_address (req_load_address),
      .load_value   (req_load_value),
      .reg_one      (reg_one_ff),
      .reg_two      (reg_two_ff),
      .pc           (pc_ff),
      .equal        (equal_ff),
      .halted       (halt_ff),
      .plan         (plan)
   );

   trcpu_ram #(
      .WIDTH (8),
      .DEPTH (LINES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The architectural registers double as the response register: a new request is
   // taken only in idle, when no response is held or the held one leaves in the same cycle.
   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign full      = {acc_ff, ram_rdata};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      issue_in     = issue_ff;
      last_idx_in  = last_idx_ff;
      rd_vld_in    = 1'b0;
      acc_in       = acc_ff;
      store_in     = store_ff;
      dest_one_in  = dest_one_ff;
      rsp_valid_in = rsp_valid_ff;
      reg_one_in   = reg_one_ff;
      reg_two_in   = reg_two_ff;
      pc_in        = pc_ff;
      equal_in     = equal_ff;
      error_in     = error_ff;
      halt_in      = halt_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;
      ram_raddr    = base_ff + {{(ADDRESS_BITS-2){1'b0}}, issue_ff};

      // Read data arrive in the cycle after the address; bytes shift in big-endian.
      if (rd_vld_ff) acc_in = full[23:0];
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + ADDRESS_BITS'(1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               reg_one_in = plan.reg_one;
               reg_two_in = plan.reg_two;
               pc_in      = plan.pc;
               equal_in   = plan.equal;
               halt_in    = plan.halt;
               if (plan.line_write) begin
                  ram_we    = 1'b1;
                  ram_waddr = plan.line_addr[ADDRESS_BITS-1:0];
                  ram_wdata = plan.line_data;
               end
               if (plan.mem_op) begin
                  state_in    = S_READ;
                  base_in     = plan.base[ADDRESS_BITS-1:0];
                  issue_in    = 2'd0;
                  last_idx_in = plan.store ? 2'd3 : 2'd1;
                  store_in    = plan.store;
                  dest_one_in = plan.dest_one;
                  acc_in      = '0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            rd_vld_in = 1'b1;
            issue_in  = issue_ff + 2'd1;
            if (issue_ff == last_idx_ff) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (store_ff) begin
               if (|full[31:ADDRESS_BITS]) begin
                  error_in     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  ptr_in   = full[ADDRESS_BITS-1:0];
                  state_in = S_WRHI;
               end
            end else begin
               if (dest_one_ff) begin
                  reg_one_in = full[15:0];
               end else begin
                  reg_two_in = full[15:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WRHI: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = reg_two_ff[15:8];
            // At the last line the low byte falls off the end of the RAM.
            if (&ptr_ff) begin
               error_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_WRLO;
            end
         end
         S_WRLO: begin
            ram_we       = 1'b1;
            ram_waddr    = ptr_ff + ADDRESS_BITS'(1);
            ram_wdata    = reg_two_ff[7:0];
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_one_ff   <= '0;
         reg_two_ff   <= '0;
         pc_ff        <= '0;
         equal_ff     <= 1'b0;
         error_ff     <= 1'b0;
         halt_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_one_ff   <= reg_one_in;
         reg_two_ff   <= reg_two_in;
         pc_ff        <= pc_in;
         equal_ff     <= equal_in;
         error_ff     <= error_in;
         halt_ff      <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      ptr_ff      <= ptr_in;
      issue_ff    <= issue_in;
      last_idx_ff <= last_idx_in;
      acc_ff      <= acc_in;
      store_ff    <= store_in;
      dest_one_ff <= dest_one_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pc_value      = pc_ff;
   assign rsp_reg_one_value = reg_one_ff;
   assign rsp_reg_two_value = reg_two_ff;
   assign rsp_equal_flag    = equal_ff;
   assign rsp_memory_error  = error_ff;
   assign rsp_halted        = halt_ff;

endmodule

>>> sim/two_register_toy_cpu_core_tb.sv
module two_register_toy_cpu_core_tb
   import trcpu_pkg::*;
();

   localparam logic [2:0] ACT_RESERVED     = 3'd5;
   localparam logic [4:0] OP_FIRST_UNUSED  = 5'd9;
   localparam logic [4:0] MOV_FIRST_UNUSED = 5'd11;
   localparam int         FIRST_HALF_END   = 700;
   localparam int         NOISY_END        = 1400;
   localparam int         QUIET_END        = 1550;
   localparam int         HOLD_AT_RESPONSE = 300;
   localparam int         HOLD_CYCLES      = 400;
   localparam int         TAIL_CYCLES      = 40;

   typedef struct packed {
      logic [15:0] pc;
      logic [15:0] one;
      logic [15:0] two;
      logic        equal;
      logic        error;
      logic        halted;
   } cpu_state_type;

   // Tracks the architectural state of the core and the responses it owes.
   class cpu_scoreboard;
      bit [7:0]      line_copy [65536];
      cpu_state_type now_state;
      cpu_state_type awaited[$];
      int            failures;
      int            matched;

      function new();
         foreach (line_copy[i]) line_copy[i] = 8'h00;
         now_state = '0;
         failures = 0;
         matched = 0;
      endfunction

      // Big-endian read; addresses wrap around the 16-bit line space.
      function logic [31:0] fetch_lines(logic [15:0] at, int count);
         logic [31:0] v;
         logic [15:0] a;
         v = '0;
         for (int i = 0; i < count; i++) begin
            a = at + 16'(i);
            v = {v[23:0], line_copy[a]};
         end
         return v;
      endfunction

      function logic [15:0] jump_target(logic [15:0] r);
         return (r < 16'd2) ? 16'd0 : r - 16'd2;
      endfunction

      function void store_through_pointer();
         logic [31:0] ptr;
         logic [15:0] next;
         ptr = fetch_lines(now_state.one, 4);
         if (ptr[31:16] != 16'h0000) begin
            now_state.error = 1'b1;
         end else begin
            line_copy[ptr[15:0]] = now_state.two[15:8];
            if (ptr[15:0] == 16'hFFFF) begin
               now_state.error = 1'b1;
            end else begin
               next = ptr[15:0] + 16'd1;
               line_copy[next] = now_state.two[7:0];
            end
         end
      endfunction

      function void run_word(logic [15:0] word);
         logic [4:0]  op;
         logic [4:0]  opnd;
         logic [15:0] back_pc;
         op = word[15:11];
         opnd = word[4:0];
         back_pc = now_state.pc - 16'd2;
         if (now_state.halted) return;
         case (op)
            OP_MOV: begin
               case (opnd)
                  MOV_ONE_TO_TWO: now_state.two = now_state.one;
                  MOV_TWO_TO_ONE: now_state.one = now_state.two;
                  MOV_ONE_TO_PC:  now_state.pc = now_state.one;
                  MOV_TWO_TO_PC:  now_state.pc = now_state.two;
                  MOV_LD_ONE_ONE: now_state.one = 16'(fetch_lines(now_state.one, 2));
                  MOV_LD_TWO_TWO: now_state.two = 16'(fetch_lines(now_state.two, 2));
                  MOV_LD_TWO_ONE: now_state.two = 16'(fetch_lines(now_state.one, 2));
                  MOV_LD_ONE_TWO: now_state.one = 16'(fetch_lines(now_state.two, 2));
                  MOV_STORE:      store_through_pointer();
                  MOV_LD_ONE_PC:  now_state.one = 16'(fetch_lines(back_pc, 2));
                  MOV_LD_TWO_PC:  now_state.two = 16'(fetch_lines(back_pc, 2));
                  default: ;
               endcase
            end
            OP_HALT: now_state.halted = 1'b1;
            OP_CMP: if (opnd == OPND_NONE) now_state.equal = (now_state.one == now_state.two);
            OP_NOT: if (opnd == OPND_NONE) now_state.one = ~now_state.one;
            OP_AND: if (opnd == OPND_NONE) now_state.one = now_state.one & now_state.two;
            OP_OR:  if (opnd == OPND_NONE) now_state.one = now_state.one | now_state.two;
            OP_XOR: if (opnd == OPND_NONE) now_state.one = now_state.one ^ now_state.two;
            OP_JMP: begin
               if (opnd == JMP_ONE) now_state.pc = jump_target(now_state.one);
               else if (opnd == JMP_TWO) now_state.pc = jump_target(now_state.two);
            end
            default: ;
         endcase
      endfunction

      function void note_request(logic [2:0] act, logic [15:0] instr, logic [15:0] laddr,
                                 logic [15:0] lval);
         case (act)
            ACT_EXECUTE: run_word(instr);
            ACT_LINE:    line_copy[laddr] = lval[7:0];
            ACT_SET_ONE: now_state.one = lval;
            ACT_SET_TWO: now_state.two = lval;
            ACT_SET_PC:  now_state.pc = lval;
            default: ;
         endcase
         awaited.push_back(now_state);
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         $display("mismatch on %s: got %h, expected %h (response %0d)",
                  what, got, want, matched);
         failures++;
      endtask

      task check_response(cpu_state_type got);
         cpu_state_type want;
         if (awaited.size() == 0) begin
            report("unexpected response pc", got.pc, 16'h0000);
            return;
         end
         want = awaited.pop_front();
         if (got.pc !== want.pc) report("pc", got.pc, want.pc);
         if (got.one !== want.one) report("reg one", got.one, want.one);
         if (got.two !== want.two) report("reg two", got.two, want.two);
         if (got.equal !== want.equal)
            report("equal flag", {15'h0, got.equal}, {15'h0, want.equal});
         if (got.error !== want.error)
            report("memory error", {15'h0, got.error}, {15'h0, want.error});
         if (got.halted !== want.halted)
            report("halted", {15'h0, got.halted}, {15'h0, want.halted});
         matched++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_action;
   logic [15:0] req_instruction;
   logic [15:0] req_load_address;
   logic [15:0] req_load_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_pc_value;
   logic [15:0] rsp_reg_one_value;
   logic [15:0] rsp_reg_two_value;
   logic        rsp_equal_flag;
   logic        rsp_memory_error;
   logic        rsp_halted;

   cpu_scoreboard sb;
   bit            idling_on;
   int            sent;
   int            store_count;
   int            load_count;

   two_register_toy_cpu_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_instruction   (req_instruction),
      .req_load_address  (req_load_address),
      .req_load_value    (req_load_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pc_value      (rsp_pc_value),
      .rsp_reg_one_value (rsp_reg_one_value),
      .rsp_reg_two_value (rsp_reg_two_value),
      .rsp_equal_flag    (rsp_equal_flag),
      .rsp_memory_error  (rsp_memory_error),
      .rsp_halted        (rsp_halted)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_request(input logic [2:0] act, input logic [15:0] instr,
                               input logic [15:0] laddr, input logic [15:0] lval);
      req_valid <= 1'b1;
      req_action <= act;
      req_instruction <= instr;
      req_load_address <= laddr;
      req_load_value <= lval;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(act, instr, laddr, lval);
      sent++;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // The bits between opcode and operand are don't-care, so they get random values.
   task automatic execute(input logic [4:0] op, input logic [4:0] opnd);
      send_request(ACT_EXECUTE, {op, 6'($urandom), opnd}, 16'($urandom), 16'($urandom));
   endtask

   task automatic set_state(input logic [2:0] act, input logic [15:0] value);
      send_request(act, 16'($urandom), 16'($urandom), value);
   endtask

   task automatic write_line(input logic [15:0] addr, input logic [7:0] data);
      send_request(ACT_LINE, 16'($urandom), addr, {8'($urandom), data});
   endtask

   // Lays a pointer down at the given line, stores reg two through it and reads it back.
   task automatic indirect_store(input logic [15:0] at, input logic [31:0] ptr,
                                 input logic [15:0] data);
      write_line(at, ptr[31:24]);
      write_line(at + 16'd1, ptr[23:16]);
      write_line(at + 16'd2, ptr[15:8]);
      write_line(at + 16'd3, ptr[7:0]);
      set_state(ACT_SET_ONE, at);
      set_state(ACT_SET_TWO, data);
      execute(OP_MOV, MOV_STORE);
      set_state(ACT_SET_ONE, ptr[15:0]);
      execute(OP_MOV, MOV_LD_ONE_ONE);
      store_count++;
   endtask

   function automatic logic [15:0] pick_address();
      logic [15:0] a;
      case ($urandom_range(0, 3))
         0: a = 16'($urandom_range(0, 31));
         1: a = 16'($urandom_range(16'hFFE0, 16'hFFFF));
         default: a = 16'($urandom);
      endcase
      return a;
   endfunction

   function automatic logic [15:0] pick_value();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'h0000;
         1: v = 16'h0001;
         2: v = 16'h0002;
         3: v = 16'hFFFF;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic run_sequence(input bit allow_error);
      logic [15:0] a;
      logic [15:0] word;
      logic [31:0] ptr;
      logic [4:0]  op;
      logic [4:0]  opnd;
      logic [2:0]  act;
      case ($urandom_range(0, 9))
         0, 1: begin
            a = pick_value();
            set_state(ACT_SET_ONE, a);
            set_state(ACT_SET_TWO, ($urandom_range(0, 2) == 0) ? a : pick_value());
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 4))
                  0: op = OP_CMP;
                  1: op = OP_NOT;
                  2: op = OP_AND;
                  3: op = OP_OR;
                  default: op = OP_XOR;
               endcase
               opnd = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(1, 31)) : OPND_NONE;
               execute(op, opnd);
            end
         end
         2, 3: begin
            a = pick_address();
            write_line(a, 8'($urandom));
            write_line(a + 16'd1, 8'($urandom));
            case ($urandom_range(0, 5))
               0: begin set_state(ACT_SET_ONE, a); execute(OP_MOV, MOV_LD_ONE_ONE); end
               1: begin set_state(ACT_SET_TWO, a); execute(OP_MOV, MOV_LD_TWO_TWO); end
               2: begin set_state(ACT_SET_ONE, a); execute(OP_MOV, MOV_LD_TWO_ONE); end
               3: begin set_state(ACT_SET_TWO, a); execute(OP_MOV, MOV_LD_ONE_TWO); end
               4: begin set_state(ACT_SET_PC, a + 16'd2); execute(OP_MOV, MOV_LD_ONE_PC); end
               default: begin
                  set_state(ACT_SET_PC, a + 16'd2);
                  execute(OP_MOV, MOV_LD_TWO_PC);
               end
            endcase
            load_count++;
         end
         4, 5: begin
            ptr = {16'h0000, pick_address()};
            if (allow_error && $urandom_range(0, 5) == 0)
               ptr = {16'($urandom_range(1, 16'hFFFF)), 16'($urandom)};
            else if (allow_error && $urandom_range(0, 15) == 0)
               ptr = 32'h0000_FFFF;
            else if (ptr[15:0] == 16'hFFFF)
               ptr[15:0] = 16'hFFFE;
            indirect_store(pick_address(), ptr, 16'($urandom));
         end
         6: begin
            set_state(ACT_SET_ONE, pick_value());
            set_state(ACT_SET_TWO, pick_value());
            execute(OP_MOV, 5'($urandom_range(MOV_ONE_TO_TWO, MOV_TWO_TO_PC)));
            execute(OP_JMP, ($urandom_range(0, 1) == 0) ? JMP_ONE : JMP_TWO);
         end
         7: begin
            case ($urandom_range(0, 4))
               0: execute(5'($urandom_range(OP_FIRST_UNUSED, 5'd31)), 5'($urandom));
               1: execute(OP_MOV, 5'($urandom_range(MOV_FIRST_UNUSED, 5'd31)));
               2: execute(OP_JMP, 5'($urandom_range(JMP_TWO + 5'd1, 5'd31)));
               3: execute(OP_NOP, 5'($urandom));
               default: send_request(3'($urandom_range(ACT_RESERVED, 3'd7)), 16'($urandom),
                                     16'($urandom), 16'($urandom));
            endcase
         end
         default: begin
            repeat ($urandom_range(1, 4)) begin
               act = 3'($urandom);
               word = 16'($urandom);
               // Halting is saved for the end; stray stores only once errors are allowed.
               if (word[15:11] == OP_HALT) word[15:11] = OP_FIRST_UNUSED;
               if (!allow_error && word[15:11] == OP_MOV && word[4:0] == MOV_STORE)
                  word[4:0] = MOV_FIRST_UNUSED;
               send_request(act, word, 16'($urandom), 16'($urandom));
            end
         end
      endcase
   endtask

   task automatic run_random_until(input int target, input bit allow_error,
                                   input bit vary_idling);
      int next_switch;
      next_switch = sent;
      while (sent < target) begin
         if (vary_idling && sent >= next_switch) begin
            idling_on = ($urandom_range(0, 3) != 0);
            next_switch = sent + 64;
         end
         run_sequence(allow_error);
      end
   endtask

   initial begin : response_side
      cpu_state_type got;
      int            hold_left;
      bit            held;
      hold_left = 0;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.pc = rsp_pc_value;
            got.one = rsp_reg_one_value;
            got.two = rsp_reg_two_value;
            got.equal = rsp_equal_flag;
            got.error = rsp_memory_error;
            got.halted = rsp_halted;
            sb.check_response(got);
         end
         // One long hold-off so that the core backs up and stalls its input.
         if (!held && sb.matched >= HOLD_AT_RESPONSE) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : run_limit
      #(10_000_000);
      $display("timeout: %0d responses still outstanding", sb.awaited.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : request_side
      sb = new();
      sent = 0;
      store_count = 0;
      load_count = 0;
      idling_on = 1'b1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_EXECUTE;
      req_instruction <= 16'h0000;
      req_load_address <= 16'h0000;
      req_load_value <= 16'h0000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register operations at the extremes, then reads that wrap around the RAM.
      set_state(ACT_SET_ONE, 16'hFFFF);
      set_state(ACT_SET_TWO, 16'h0000);
      execute(OP_CMP, OPND_NONE);
      execute(OP_XOR, OPND_NONE);
      execute(OP_AND, OPND_NONE);
      execute(OP_OR, OPND_NONE);
      execute(OP_NOT, OPND_NONE);
      execute(OP_MOV, MOV_ONE_TO_TWO);
      execute(OP_CMP, OPND_NONE);
      write_line(16'hFFFF, 8'hA5);
      write_line(16'h0000, 8'h5A);
      execute(OP_MOV, MOV_LD_ONE_ONE);
      set_state(ACT_SET_PC, 16'h0001);
      execute(OP_MOV, MOV_LD_TWO_PC);
      set_state(ACT_SET_ONE, 16'h0001);
      execute(OP_JMP, JMP_ONE);
      execute(OP_MOV, MOV_TWO_TO_PC);
      execute(OP_JMP, JMP_TWO);
      execute(OP_NOP, OPND_NONE);
      execute(5'd31, 5'd31);
      execute(OP_CMP, 5'd31);
      execute(OP_MOV, 5'd31);
      send_request(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      run_random_until(FIRST_HALF_END, 1'b0, 1'b1);

      // A good store, a store that lands on the last line, and one past the end.
      indirect_store(16'h0010, 32'h0000_0040, 16'hBEEF);
      indirect_store(16'h0020, 32'h0000_FFFF, 16'hC3A1);
      indirect_store(16'h0030, 32'h0001_0000, 16'h1234);

      run_random_until(NOISY_END, 1'b1, 1'b1);
      idling_on = 1'b0;
      run_random_until(QUIET_END, 1'b1, 1'b0);

      // After a halt only the load actions still change anything.
      execute(OP_HALT, OPND_NONE);
      execute(OP_NOT, OPND_NONE);
      set_state(ACT_SET_ONE, 16'h1234);
      execute(OP_MOV, MOV_ONE_TO_TWO);
      write_line(16'h0100, 8'h77);
      set_state(ACT_SET_PC, 16'h8000);
      execute(OP_JMP, JMP_ONE);
      set_state(ACT_SET_TWO, 16'hABCD);
      req_valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests with %0d indirect stores and %0d two-line loads,",
               sent, store_count, load_count);
      $display("including wrapped reads, jump floors, sticky errors and a final halt.");
      if (sb.failures == 0 && sb.awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/trcpu_pkg.sv
sv/trcpu_ram.sv
sv/trcpu_decode.sv
sv/two_register_toy_cpu_core.sv
sim/two_register_toy_cpu_core_tb.sv
